// ===== hw/rtl/mcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Multichannel 3x3 convolution package
// Shared widths, register indexes and the record passed from front to back.
// ----------------------------------------------------------------------------
package mcc_pkg;

  localparam int MaxWidth    = 256;
  localparam int MaxChannels = 64;
  localparam int KernelTaps  = 9;
  localparam int MaxHeight   = 1024;
  localparam int PaddedCols  = MaxWidth + 2;

  localparam int ChW   = $clog2(MaxChannels);
  localparam int ColW  = $clog2(PaddedCols);
  localparam int WIdxW = $clog2(KernelTaps * MaxChannels);
  localparam int LineDepth = PaddedCols * MaxChannels;
  localparam int LineAw    = $clog2(LineDepth);

  typedef enum logic [1:0] {
    REG_WIDTH   = 2'd0,
    REG_HEIGHT  = 2'd1,
    REG_CHANNEL = 2'd2,
    REG_BIAS    = 2'd3
  } reg_index_t;

  // One classified item as handed to the datapath. A weight item uses only
  // px, ch and tap.
  typedef struct packed {
    logic signed [15:0] px;
    logic [ChW-1:0]     ch;
    logic [3:0]         tap;
    logic               wt;
    logic [ColW-1:0]    col;
    logic               slot;
    logic               interior;
    logic               final_ch;
    logic [9:0]         orow;
    logic [7:0]         ocol;
    logic               last;
  } pix_t;

endpackage

// ===== hw/rtl/mcc_front.sv =====
// ----------------------------------------------------------------------------
// Convolution front end
// Accepts items, splits weight indexes, tracks the frame position of pixels.
// ----------------------------------------------------------------------------
module mcc_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     op,
  input  logic signed [15:0]       sample,
  input  logic [9:0]               weight_index,
  input  logic [8:0]               frame_width,
  input  logic [10:0]              frame_height,
  input  logic [6:0]               channel_count,
  input  logic                     restart,
  input  logic                     q_ready,
  output logic                     q_valid,
  output mcc_pkg::pix_t            q_data
);

  logic [10:0] row_count;
  logic [mcc_pkg::ColW-1:0] col_count;
  logic [mcc_pkg::ChW-1:0]  chan_count;
  logic [8:0]  w_eff;
  logic [10:0] h_eff;
  logic [6:0]  n_eff;
  logic        take_px;
  logic        ch_wrap;
  logic        col_wrap;
  logic        w_ok;
  logic [19:0] wprod;
  logic [mcc_pkg::ChW-1:0] wch;
  logic [9:0]  wbase;
  logic [3:0]  wtap;

  always_comb begin
    w_eff = (frame_width == 9'd0) ? 9'd1 :
            (frame_width > 9'(mcc_pkg::MaxWidth)) ? 9'(mcc_pkg::MaxWidth) : frame_width;
    h_eff = (frame_height == 11'd0) ? 11'd1 :
            (frame_height > 11'(mcc_pkg::MaxHeight)) ? 11'(mcc_pkg::MaxHeight) : frame_height;
    n_eff = (channel_count == 7'd0) ? 7'd1 :
            (channel_count > 7'(mcc_pkg::MaxChannels)) ? 7'(mcc_pkg::MaxChannels)
                                                      : channel_count;
  end

  // Weights travel through the queue as well so that they land in stream
  // order; writes beyond the weight store are dropped here.
  assign w_ok     = weight_index < 10'(mcc_pkg::KernelTaps * mcc_pkg::MaxChannels);
  assign in_ready = q_ready;
  assign take_px  = in_valid & q_ready & ~op;
  assign ch_wrap  = ({1'b0, chan_count} + 7'd1) >= n_eff;
  assign col_wrap = {1'b0, col_count} >= {1'b0, w_eff} + 10'd1;

  // Channel is the index over nine, by a reciprocal multiplication that is
  // exact over the whole store; the tap is what remains.
  assign wprod = {10'd0, weight_index} * 20'd911;
  assign wch   = wprod[13 +: mcc_pkg::ChW];
  assign wbase = 10'(wch) * 10'd9;
  assign wtap  = 4'(weight_index - wbase);

  always_comb begin
    q_valid           = in_valid & q_ready & (~op | w_ok);
    q_data.px         = sample;
    q_data.ch         = op ? wch : chan_count;
    q_data.tap        = wtap;
    q_data.wt         = op;
    q_data.col        = col_count;
    q_data.slot       = row_count[0];
    q_data.interior   = (row_count >= 11'd2) && (col_count >= mcc_pkg::ColW'(2));
    q_data.final_ch   = ch_wrap;
    q_data.orow       = 10'(row_count - 11'd2);
    q_data.ocol       = 8'(col_count - mcc_pkg::ColW'(2));
    q_data.last       = (row_count == h_eff + 11'd1) && ({1'b0, col_count} == {1'b0, w_eff} + 10'd1);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row_count  <= '0;
      col_count  <= '0;
      chan_count <= '0;
    end else if (take_px) begin
      if (ch_wrap) begin
        chan_count <= '0;
        if (col_wrap) begin
          col_count <= '0;
          row_count <= (row_count >= h_eff + 11'd1) ? 11'd0 : row_count + 11'd1;
        end else begin
          col_count <= col_count + mcc_pkg::ColW'(1);
        end
      end else begin
        chan_count <= chan_count + mcc_pkg::ChW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/mcc_queue.sv =====
// ----------------------------------------------------------------------------
// Convolution item queue
// Four-entry queue between front end and datapath.
// ----------------------------------------------------------------------------
module mcc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  mcc_pkg::pix_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output mcc_pkg::pix_t rd_data
);

  mcc_pkg::pix_t ent [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] cnt;
  logic       push;
  logic       pop;

  assign wr_ready = cnt != 3'd4;
  assign rd_valid = cnt != 3'd0;
  assign rd_data  = ent[rp];
  assign push     = wr_valid & wr_ready;
  assign pop      = rd_valid & rd_ready;

  always_ff @(posedge clk) begin
    if (push) ent[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (pop)  rp <= rp + 2'd1;
      cnt <= cnt + {2'b0, push} - {2'b0, pop};
    end
  end

endmodule

// ===== hw/rtl/mcc_back.sv =====
// ----------------------------------------------------------------------------
// Convolution datapath
// Memory reads, window update, nine products, channel sum and output stage.
// ----------------------------------------------------------------------------
module mcc_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       restart,
  input  logic signed [47:0]         bias,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  mcc_pkg::pix_t              q_data,
  output logic                       m_valid,
  input  logic                       m_ready,
  output logic signed [47:0]         result,
  output logic [9:0]                 out_row,
  output logic [7:0]                 out_col,
  output logic                       last
);

  // Memories: weights by channel row of nine, lines as two banks.
  logic [9*16-1:0]     wmem [mcc_pkg::MaxChannels];
  logic signed [15:0]  lmem0 [mcc_pkg::LineDepth];
  logic signed [15:0]  lmem1 [mcc_pkg::LineDepth];
  logic [6*16-1:0]     cwin [mcc_pkg::MaxChannels];

  // Stage 1: memory read.
  logic          s1_v;
  mcc_pkg::pix_t s1;
  logic [9*16-1:0] s1_w;
  logic signed [15:0] s1_l0;
  logic signed [15:0] s1_l1;
  logic [6*16-1:0] s1_cwr;
  logic [6*16-1:0] s1_cw;
  // Stage 2: products.
  logic          s2_v;
  mcc_pkg::pix_t s2;
  logic signed [31:0] s2_p [9];
  logic signed [15:0] s2_px;
  logic [6*16-1:0] s2_cwn;
  // Stage 3: channel sum.
  logic          s3_v;
  mcc_pkg::pix_t s3;
  logic signed [35:0] s3_sum;
  logic signed [47:0] acc;
  logic          adv;
  logic          m_free;
  logic [mcc_pkg::LineAw-1:0] la;
  logic [mcc_pkg::LineAw-1:0] s1_la;
  logic signed [15:0] win [9];
  logic signed [15:0] s1_l0_f;
  logic signed [15:0] s1_l1_f;
  logic fwd;
  logic [6*16-1:0] cwn;

  assign m_free  = ~m_valid | m_ready;
  assign adv     = m_free;
  assign q_ready = adv;
  assign la      = mcc_pkg::LineAw'({1'b0, q_data.col} * mcc_pkg::MaxChannels + q_data.ch);

  // A weight item writes one tap lane of its channel row as it leaves the queue.
  always_ff @(posedge clk) begin
    if (adv && q_valid && q_data.wt) wmem[q_data.ch][q_data.tap*16 +: 16] <= q_data.px;
  end

  // Write into a line bank as the item leaves stage 1, after the read of that item.
  always_ff @(posedge clk) begin
    if (adv && q_valid) begin
      s1_l0  <= lmem0[la];
      s1_l1  <= lmem1[la];
      s1_w   <= wmem[q_data.ch];
      s1_cwr <= cwin[q_data.ch];
    end
    if (adv && s1_v) begin
      if (s1.slot) lmem1[s1_la] <= s1.px;
      else         lmem0[s1_la] <= s1.px;
    end
  end

  // Forward the just-written line entry when consecutive items hit it (one channel).
  assign fwd = s2_v && (s2.ch == s1.ch) && (s2.col == s1.col) && (s2.slot == s1.slot);

  always_comb begin
    s1_l0_f = s1_l0;
    s1_l1_f = s1_l1;
    if (fwd) begin
      if (s2.slot) s1_l1_f = s2_px;
      else         s1_l0_f = s2_px;
    end
    // The column window of the item just ahead was written as this one read it.
    s1_cw   = s1_cwr;
    if (s2_v && s2.ch == s1.ch) s1_cw = s2_cwn;
    // Window rows: top, middle, current.
    win[0] = s1_cw[0*16 +: 16];
    win[3] = s1_cw[1*16 +: 16];
    win[6] = s1_cw[2*16 +: 16];
    win[1] = s1_cw[3*16 +: 16];
    win[4] = s1_cw[4*16 +: 16];
    win[7] = s1_cw[5*16 +: 16];
    win[2] = s1.slot ? s1_l1_f : s1_l0_f;
    win[5] = s1.slot ? s1_l0_f : s1_l1_f;
    win[8] = s1.px;
  end

  assign cwn = {win[8], win[5], win[2], win[7], win[4], win[1]};

  always_ff @(posedge clk) begin
    if (adv && s1_v) cwin[s1.ch] <= cwn;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (q_valid) begin
        s1    <= q_data;
        s1_la <= la;
      end
      if (s1_v) begin
        s2     <= s1;
        s2_px  <= s1.px;
        s2_cwn <= cwn;
        for (int i = 0; i < 9; i++) begin
          s2_p[i] <= win[i] * $signed(s1_w[i*16 +: 16]);
        end
      end
      if (s2_v) begin
        s3     <= s2;
        s3_sum <= ((36'(s2_p[0]) + 36'(s2_p[1])) + (36'(s2_p[2]) + 36'(s2_p[3])))
                + ((36'(s2_p[4]) + 36'(s2_p[5])) + (36'(s2_p[6]) + 36'(s2_p[7])))
                + 36'(s2_p[8]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      acc  <= '0;
    end else if (adv) begin
      s1_v <= q_valid & ~q_data.wt;
      s2_v <= s1_v;
      s3_v <= s2_v;
      if (s3_v && s3.interior) begin
        acc <= s3.final_ch ? 48'sd0 : acc + 48'(s3_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= s3_v && s3.interior && s3.final_ch;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_v) begin
      result  <= bias + acc + 48'(s3_sum);
      out_row <= s3.orow;
      out_col <= s3.ocol;
      last    <= s3.last;
    end
  end

endmodule

// ===== hw/rtl/multichannel_conv3x3.sv =====
// ----------------------------------------------------------------------------
// Multichannel 3x3 convolution with bias
// Channel | dir | handshake | payload
// s_axis  | in  | tvalid/tready | tdata {weight_index, sample}, tuser op
// m_axis  | out | tvalid/tready | tdata {out_col, out_row, result}, tlast last
// apb     | in  | psel/penable  | four registers at 8*i, 64-bit data
// One item a cycle sustained while the output is not stalled; a pixel's
// result passes through the read, multiply, sum and output stages. Weight
// items share the queue with pixels so that they take effect in stream
// order. Reset is synchronous and clears all control state; a stalled
// output holds the whole datapath and the queue then fills.
// ----------------------------------------------------------------------------
module multichannel_conv3x3 (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // sample[15:0], weight_index[25:16]
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // result[47:0], out_row[57:48], out_col[65:58]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [8:0]  frame_width;
  logic [10:0] frame_height;
  logic [6:0]  channel_count;
  logic signed [47:0] bias;
  logic        wr;
  logic        restart;
  mcc_pkg::reg_index_t ridx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign ridx   = mcc_pkg::reg_index_t'(paddr[4:3]);
  assign restart = wr && (ridx != mcc_pkg::REG_BIAS);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= 9'd1;
      frame_height  <= 11'd1;
      channel_count <= 7'd1;
      bias          <= '0;
    end else if (wr) begin
      case (ridx)
        mcc_pkg::REG_WIDTH:   frame_width   <= pwdata[8:0];
        mcc_pkg::REG_HEIGHT:  frame_height  <= pwdata[10:0];
        mcc_pkg::REG_CHANNEL: channel_count <= pwdata[6:0];
        mcc_pkg::REG_BIAS:    bias          <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      mcc_pkg::REG_WIDTH:   prdata = {55'd0, frame_width};
      mcc_pkg::REG_HEIGHT:  prdata = {53'd0, frame_height};
      mcc_pkg::REG_CHANNEL: prdata = {57'd0, channel_count};
      mcc_pkg::REG_BIAS:    prdata = {16'd0, bias};
      default:              prdata = '0;
    endcase
  end

  logic          fq_valid;
  logic          fq_ready;
  mcc_pkg::pix_t fq_data;
  logic          qb_valid;
  logic          qb_ready;
  mcc_pkg::pix_t qb_data;
  logic signed [47:0] result;
  logic [9:0]  out_row;
  logic [7:0]  out_col;

  mcc_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .op(s_axis_tuser), .sample(s_axis_tdata[15:0]), .weight_index(s_axis_tdata[25:16]),
    .frame_width, .frame_height, .channel_count, .restart,
    .q_ready(fq_ready), .q_valid(fq_valid), .q_data(fq_data)
  );

  mcc_queue u_queue (
    .clk, .rst(rst | restart),
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
  );

  mcc_back u_back (
    .clk, .rst, .restart, .bias,
    .q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
    .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
    .result, .out_row, .out_col, .last(m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, out_col, out_row, result};

endmodule
